// File: sv/tepf_pkg.sv
// ----------------------------------------------------------------------------
// tepf_pkg: shared types and constants for the tcp egress port filter
// Item and result words, table geometry, controller/datapath command
// and status structs.
// ----------------------------------------------------------------------------
package tepf_pkg;

  localparam int TableEntries = 256;
  localparam int IdxW         = $clog2(TableEntries);
  localparam logic [15:0] FIXED_BLOCKED_PORT = 16'd6379;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_SET    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  // reserved kind, ignored by the block
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] REASON_NONE  = 2'd0;
  localparam logic [1:0] REASON_FIXED = 2'd1;
  localparam logic [1:0] REASON_TABLE = 2'd2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic [15:0] entry_port;
    logic [7:0]  entry_value;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic        drop;
    logic [1:0]  drop_reason;
    logic [15:0] seen_port;
    logic [1:0]  update_status;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic parse;     // apply packet byte to parse state
    logic scan_clr;  // restart table scan
    logic scan_step; // read next table entry
    logic write;     // commit table write at chosen slot
    logic build;     // register result word
  } tepf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       last_byte;
    logic       scan_done;
  } tepf_sts_t;

endpackage

// File: sv/tepf_datapath.sv
// ----------------------------------------------------------------------------
// tepf_datapath: parse registers, port table memory and scan logic
// The table is scanned one entry a cycle through a registered read port.
// ----------------------------------------------------------------------------
module tepf_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tepf_pkg::in_word_t   in_word,
  input  tepf_pkg::tepf_cmd_t  cmd,
  output tepf_pkg::tepf_sts_t  sts,
  output tepf_pkg::out_word_t  res_word
);

  localparam int IW = tepf_pkg::IdxW;

  tepf_pkg::in_word_t item_r;

  logic [6:0]  off_r;
  logic [7:0]  vl_r;
  logic [7:0]  proto_r;
  logic [15:0] port_r;
  logic        pkt_ok_r;

  // table storage, valid bits in flops
  logic [15:0] keys_mem [tepf_pkg::TableEntries];
  logic [7:0]  vals_mem [tepf_pkg::TableEntries];
  logic [tepf_pkg::TableEntries-1:0] valid_r;

  logic [IW:0]   rd_idx_r;   // next address to read
  logic          rd_vld_r;   // read data below is live
  logic [IW-1:0] rd_at_r;
  logic [15:0]   rd_key_r;
  logic [7:0]    rd_val_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [7:0]    hit_val_r;
  logic          free_r;
  logic [IW-1:0] free_idx_r;

  tepf_pkg::out_word_t res_r;
  tepf_pkg::out_word_t res_nxt;

  logic [15:0] key;
  logic [7:0]  hl;
  logic [7:0]  len;
  logic [7:0]  b;
  logic [7:0]  vl_n;
  logic [7:0]  proto_n;
  logic [15:0] port_n;
  logic        pkt_ok;

  // search key: parsed port for a verdict, entry port for updates
  assign key = (item_r.kind == tepf_pkg::KIND_BYTE) ? port_r : item_r.entry_port;

  // parse combinational update of current byte
  always_comb begin
    b       = item_r.packet_byte;
    vl_n    = (off_r == 7'd0) ? b : vl_r;
    proto_n = (off_r == 7'd9) ? b : proto_r;
    hl      = {2'b00, vl_n[3:0], 2'b00};
    port_n  = port_r;
    if ({1'b0, off_r} == hl + 8'd2) port_n[15:8] = b;
    if ({1'b0, off_r} == hl + 8'd3) port_n[7:0]  = b;
    len     = {1'b0, off_r} + 8'd1;
    pkt_ok  = (len >= 8'd20) && (vl_n[7:4] == 4'd4) && (proto_n == 8'd6) &&
              (hl >= 8'd20) && (len >= hl + 8'd20);
  end

  // item capture and packet parse state
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_word;
    if (!rst_n) begin
      off_r <= '0; vl_r <= '0; proto_r <= '0; port_r <= '0; pkt_ok_r <= 1'b0;
    end else if (cmd.parse) begin
      if (item_r.last_byte) begin
        // port held for the verdict scan
        off_r <= '0; vl_r <= '0; proto_r <= '0; port_r <= port_n;
      end else begin
        vl_r <= vl_n; proto_r <= proto_n; port_r <= port_n;
        if (off_r != 7'd127) off_r <= off_r + 7'd1;
      end
      pkt_ok_r <= pkt_ok;
    end else if (cmd.build && item_r.kind == tepf_pkg::KIND_BYTE) begin
      port_r <= '0;
    end
  end

  // table memory read and write ports
  always_ff @(posedge clk) begin
    if (cmd.write && item_r.kind == tepf_pkg::KIND_SET && (hit_r || free_r)) begin
      keys_mem[hit_r ? hit_idx_r : free_idx_r] <= item_r.entry_port;
      vals_mem[hit_r ? hit_idx_r : free_idx_r] <= item_r.entry_value;
    end
    rd_key_r <= keys_mem[rd_idx_r[IW-1:0]];
    rd_val_r <= vals_mem[rd_idx_r[IW-1:0]];
  end

  // scan sequencing and match tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; rd_idx_r <= '0; rd_vld_r <= 1'b0; hit_r <= 1'b0; free_r <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        rd_idx_r <= '0; rd_vld_r <= 1'b0; hit_r <= 1'b0; free_r <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_vld_r <= !rd_idx_r[IW];
        rd_at_r  <= rd_idx_r[IW-1:0];
        if (!rd_idx_r[IW]) rd_idx_r <= rd_idx_r + {{IW{1'b0}}, 1'b1};
        if (rd_vld_r) begin
          if (valid_r[rd_at_r] && rd_key_r == key && !hit_r) begin
            hit_r <= 1'b1; hit_idx_r <= rd_at_r; hit_val_r <= rd_val_r;
          end
          if (!valid_r[rd_at_r] && !free_r) begin
            free_r <= 1'b1; free_idx_r <= rd_at_r;
          end
        end
      end
      if (cmd.write) begin
        if (item_r.kind == tepf_pkg::KIND_SET && (hit_r || free_r))
          valid_r[hit_r ? hit_idx_r : free_idx_r] <= 1'b1;
        if (item_r.kind == tepf_pkg::KIND_REMOVE && hit_r)
          valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  // result word contents
  always_comb begin
    res_nxt = '0;
    if (item_r.kind == tepf_pkg::KIND_BYTE) begin
      if (pkt_ok_r) begin
        res_nxt.seen_port = port_r;
        if (port_r == tepf_pkg::FIXED_BLOCKED_PORT) begin
          res_nxt.drop = 1'b1; res_nxt.drop_reason = tepf_pkg::REASON_FIXED;
        end else if (hit_r && hit_val_r == 8'd1) begin
          res_nxt.drop = 1'b1; res_nxt.drop_reason = tepf_pkg::REASON_TABLE;
        end
      end
    end else begin
      res_nxt.result_kind = 1'b1;
      if (item_r.kind == tepf_pkg::KIND_SET && !hit_r && !free_r)
        res_nxt.update_status = tepf_pkg::STATUS_FULL;
      if (item_r.kind == tepf_pkg::KIND_REMOVE && !hit_r)
        res_nxt.update_status = tepf_pkg::STATUS_MISSING;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.build) res_r <= res_nxt;
  end

  assign res_word = res_r;

  assign sts.kind      = item_r.kind;
  assign sts.last_byte = item_r.last_byte;
  assign sts.scan_done = rd_idx_r[IW] && !rd_vld_r;

endmodule

// File: sv/tepf_ctrl.sv
// ----------------------------------------------------------------------------
// tepf_ctrl: sequencer for byte parse, table scan, update and result hand-off
// ----------------------------------------------------------------------------
module tepf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tepf_pkg::tepf_sts_t  sts,
  output tepf_pkg::tepf_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DEC   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_BUILD = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;

  assign out_valid = ovld_r;
  // input open only when no word is in flight or pending
  assign in_stall  = !(state_r == ST_IDLE || (state_r == ST_OUT && !ovld_r));

  always_comb begin
    state_nxt = state_r;
    ovld_nxt  = ovld_r && out_stall;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE, ST_OUT: begin
        if (state_r == ST_OUT && ovld_r) begin
          if (!out_stall) state_nxt = ST_IDLE;
        end else if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DEC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DEC: begin
        cmd.scan_clr = 1'b1;
        if (sts.kind == tepf_pkg::KIND_BYTE) begin
          cmd.parse = 1'b1;
          state_nxt = sts.last_byte ? ST_SCAN : ST_IDLE;
        end else if (sts.kind == tepf_pkg::KIND_SET || sts.kind == tepf_pkg::KIND_REMOVE) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.scan_step = 1'b0;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write = (sts.kind != tepf_pkg::KIND_BYTE);
        state_nxt = ST_BUILD;
      end
      ST_BUILD: begin
        cmd.build = 1'b1;
        ovld_nxt  = 1'b1;
        state_nxt = ST_OUT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

// File: sv/tcp_egress_port_filter.sv
// ----------------------------------------------------------------------------
// tcp_egress_port_filter: outbound ipv4 tcp destination port filter
//
//   channel | direction | word            | handshake
//   in_     | input     | in_word_t       | in_valid / in_stall
//   out_    | output    | out_word_t      | out_valid / out_stall
//
// A non-final packet byte is taken in the idle state, then parsed in the
// decode state. A final byte or a table update raises out_valid once the
// table has been searched, one entry a cycle through its registered read
// port, and the result word is registered; the next word is then taken
// only once that result word is taken. Synchronous reset empties the
// table at once through per-entry valid flops. A stalled result word
// holds and the input stays stalled until it is taken.
// ----------------------------------------------------------------------------
module tcp_egress_port_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tepf_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output tepf_pkg::out_word_t out_word
);

  tepf_pkg::tepf_cmd_t cmd;
  tepf_pkg::tepf_sts_t sts;

  tepf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  tepf_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_word), .cmd(cmd), .sts(sts),
    .res_word(out_word)
  );

endmodule

// File: sv/tepf_checker.sv
// ----------------------------------------------------------------------------
// tepf_checker: port-level checks for the tcp egress port filter
// ----------------------------------------------------------------------------
module tepf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tepf_pkg::out_word_t out_word
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word)) else $error("word dropped");

  // a verdict never carries an update status
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.result_kind |-> out_word.update_status == tepf_pkg::STATUS_DONE)
    else $error("verdict has status");

  // an update status never drops
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.result_kind |-> !out_word.drop && out_word.seen_port == 16'd0)
    else $error("status has verdict");

  // drop and reason agree
  a_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.drop == (out_word.drop_reason != tepf_pkg::REASON_NONE))
    else $error("reason mismatch");

  // no input taken while a word is held stalled
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && in_valid |-> in_stall) else $error("input taken under stall");

endmodule

bind tcp_egress_port_filter tepf_checker u_tepf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
